// ----- design/midi_track_event_parser_macros.svh -----
// assertion macros for the midi track event parser
// no dependencies; included inside modules that see aclk and aresetn
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// property that holds in every cycle out of reset
`define MTEP_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// condition in this cycle implies a condition in the next cycle
`define MTEP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/mtep_pkg.sv -----
// shared types, codes and helpers for the midi track event parser
// no dependencies
package mtep_pkg;

    localparam logic [2:0] KIND_CHAN  = 3'd0;
    localparam logic [2:0] KIND_SYSEX = 3'd1;
    localparam logic [2:0] KIND_MDONE = 3'd2;
    localparam logic [2:0] KIND_MBYTE = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    localparam logic [7:0]  STATUS_SYSEX = 8'hF0;
    localparam logic [7:0]  STATUS_META  = 8'hFF;
    localparam logic [7:0]  SYSEX_END    = 8'hF7;
    localparam logic [7:0]  META_TEMPO   = 8'h51;
    localparam logic [7:0]  META_END     = 8'h2F;
    localparam logic [3:0]  HI_PROG      = 4'hC;
    localparam logic [3:0]  HI_PRESSURE  = 4'hD;
    localparam logic [23:0] TEMPO_RESET  = 24'd500000;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_DATA1  = 8'b0000_0100,
        PH_DATA2  = 8'b0000_1000,
        PH_SYSEX  = 8'b0001_0000,
        PH_MTYPE  = 8'b0010_0000,
        PH_MLEN   = 8'b0100_0000,
        PH_MDATA  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta_ticks;
        logic [31:0] abs_tick;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  meta_kind;
        logic [27:0] meta_size;
        logic [7:0]  payload_byte;
        logic [23:0] tempo_us;
        logic        last;
    } res_t;

    function automatic res_t make_res(
        input logic [2:0]  kind,
        input logic [27:0] delta,
        input logic [31:0] tick,
        input logic [7:0]  status,
        input logic [7:0]  d1,
        input logic [7:0]  d2,
        input logic [7:0]  mtype,
        input logic [27:0] mlen,
        input logic [7:0]  pay,
        input logic [23:0] tempo,
        input logic        last
    );
        res_t r;
        logic meta;
        meta = (kind == KIND_MDONE) || (kind == KIND_MBYTE);
        r.kind         = kind;
        r.delta_ticks  = delta;
        r.abs_tick     = tick;
        r.status_byte  = status;
        r.first_data   = d1;
        r.second_data  = d2;
        r.meta_kind    = meta ? mtype : 8'd0;
        r.meta_size    = meta ? mlen : 28'd0;
        r.payload_byte = pay;
        r.tempo_us     = tempo;
        r.last         = last;
        return r;
    endfunction

endpackage

// ----- design/midi_track_event_parser.sv -----
// midi track event parser: byte-wide event decoder with a small result queue
// depends on mtep_pkg and midi_track_event_parser_macros.svh
//
//   channel   ports                 width  meaning
//   s_        s_byte_in             8      track event bytes, one per request
//   m_        m_kind .. m_last      156    decoded results, up to two per byte
//
// one byte is decoded per cycle by the phase logic while s_ready is high; its results
// enter a four-entry result queue in the same edge, so a byte can be taken every cycle.
// s_ready is high while the queue has room for two results.
// m_ lines come straight from the queue head; a stalled m_ready only stops
// input once the queue holds three results.
// aresetn is synchronous, active low, and clears phase, counters and queue.
module midi_track_event_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [27:0] m_delta_ticks,
    output logic [31:0] m_abs_tick,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_first_data,
    output logic [7:0]  m_second_data,
    output logic [7:0]  m_meta_kind,
    output logic [27:0] m_meta_size,
    output logic [7:0]  m_payload_byte,
    output logic [23:0] m_tempo_us,
    output logic        m_last
);
    import mtep_pkg::*;
    `include "midi_track_event_parser_macros.svh"

    phase_t      phase_reg, phase_next;
    logic [27:0] delta_reg, delta_next;
    logic [31:0] tick_reg, tick_next;
    logic [7:0]  rs_reg, rs_next;
    logic [7:0]  es_reg, es_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [27:0] mlen_reg, mlen_next;
    logic [27:0] pcount_reg, pcount_next;
    logic [23:0] tshift_reg, tshift_next;
    logic [23:0] tempo_reg, tempo_next;

    res_t        fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    res_t        r0, r1;
    logic        r0_valid, r1_valid;
    logic        accept, pop;
    logic [7:0]  b;
    logic [27:0] dnew, lnew;
    logic [3:0]  hi;
    logic [23:0] tshift_upd;

    assign b      = s_byte_in;
    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;

    always_comb begin
        phase_next  = phase_reg;
        delta_next  = delta_reg;
        tick_next   = tick_reg;
        rs_next     = rs_reg;
        es_next     = es_reg;
        held_next   = held_reg;
        mtype_next  = mtype_reg;
        mlen_next   = mlen_reg;
        pcount_next = pcount_reg;
        tshift_next = tshift_reg;
        tempo_next  = tempo_reg;
        r0_valid    = 1'b0;
        r1_valid    = 1'b0;
        r0          = '0;
        r1          = '0;
        dnew        = {delta_reg[20:0], b[6:0]};
        lnew        = {mlen_reg[20:0], b[6:0]};
        hi          = rs_reg[7:4];
        tshift_upd  = tshift_reg;
        case (phase_reg)
            PH_DELTA: begin
                delta_next = dnew;
                if (!b[7]) begin
                    tick_next  = tick_reg + {4'd0, dnew};
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b[7]) begin
                    // explicit status
                    rs_next = b;
                    es_next = b;
                    hi      = b[7:4];
                    if (hi inside {[4'h8:4'hE]}) begin
                        held_next  = 8'd0;
                        phase_next = PH_DATA1;
                    end else if (b == STATUS_SYSEX) begin
                        phase_next = PH_SYSEX;
                    end else if (b == STATUS_META) begin
                        phase_next = PH_MTYPE;
                    end else begin
                        delta_next = 28'd0;
                        phase_next = PH_DELTA;
                    end
                end else begin
                    // running status, byte is handled here as the first byte of the new phase
                    es_next = rs_reg;
                    if (hi inside {[4'h8:4'hE]}) begin
                        held_next = b;
                        if (hi == HI_PROG || hi == HI_PRESSURE) begin
                            r0_valid   = 1'b1;
                            r0         = make_res(KIND_CHAN, delta_reg, tick_reg, rs_reg, b,
                                                  8'd0, mtype_reg, mlen_reg, 8'd0, tempo_reg,
                                                  1'b0);
                            delta_next = 28'd0;
                            phase_next = PH_DELTA;
                        end else begin
                            phase_next = PH_DATA2;
                        end
                    end else if (rs_reg == STATUS_SYSEX) begin
                        r0_valid   = 1'b1;
                        r0         = make_res(KIND_SYSEX, delta_reg, tick_reg, rs_reg, 8'd0,
                                              8'd0, mtype_reg, mlen_reg, b, tempo_reg,
                                              1'b0);
                        phase_next = PH_SYSEX;
                    end else if (rs_reg == STATUS_META) begin
                        mtype_next  = b;
                        mlen_next   = 28'd0;
                        pcount_next = 28'd0;
                        tshift_next = 24'd0;
                        phase_next  = PH_MLEN;
                    end else begin
                        // no prior status gives an error, other system status nothing;
                        // the data byte then completes a one-byte delta
                        if (!hi[3]) begin
                            r0_valid = 1'b1;
                            r0       = make_res(KIND_ERR, delta_reg, tick_reg, rs_reg, 8'd0,
                                                8'd0, mtype_reg, mlen_reg, 8'd0, tempo_reg,
                                                1'b0);
                        end
                        delta_next = {21'd0, b[6:0]};
                        tick_next  = tick_reg + {25'd0, b[6:0]};
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_DATA1: begin
                held_next = b;
                if (es_reg[7:4] == HI_PROG || es_reg[7:4] == HI_PRESSURE) begin
                    r0_valid   = 1'b1;
                    r0         = make_res(KIND_CHAN, delta_reg, tick_reg, es_reg, b, 8'd0,
                                          mtype_reg, mlen_reg, 8'd0, tempo_reg, 1'b0);
                    delta_next = 28'd0;
                    phase_next = PH_DELTA;
                end else begin
                    phase_next = PH_DATA2;
                end
            end
            PH_DATA2: begin
                r0_valid   = 1'b1;
                r0         = make_res(KIND_CHAN, delta_reg, tick_reg, es_reg, held_reg, b,
                                      mtype_reg, mlen_reg, 8'd0, tempo_reg, 1'b0);
                delta_next = 28'd0;
                phase_next = PH_DELTA;
            end
            PH_SYSEX: begin
                r0_valid = 1'b1;
                r0       = make_res(KIND_SYSEX, delta_reg, tick_reg, es_reg, 8'd0, 8'd0,
                                    mtype_reg, mlen_reg, b, tempo_reg, b == SYSEX_END);
                if (b == SYSEX_END) begin
                    delta_next = 28'd0;
                    phase_next = PH_DELTA;
                end
            end
            PH_MTYPE: begin
                mtype_next  = b;
                mlen_next   = 28'd0;
                pcount_next = 28'd0;
                tshift_next = 24'd0;
                phase_next  = PH_MLEN;
            end
            PH_MLEN: begin
                mlen_next = lnew;
                if (!b[7]) begin
                    if (lnew == 28'd0) begin
                        // empty meta event completes at once
                        if (mtype_reg == META_TEMPO) begin
                            tempo_next = tshift_reg;
                        end
                        r0_valid = 1'b1;
                        r0       = make_res(KIND_MDONE, delta_reg, tick_reg, es_reg, 8'd0,
                                            8'd0, mtype_reg, lnew, 8'd0,
                                            (mtype_reg == META_TEMPO) ? tshift_reg : tempo_reg,
                                            1'b0);
                        if (mtype_reg == META_END) begin
                            tick_next = 32'd0;
                        end
                        delta_next = 28'd0;
                        phase_next = PH_DELTA;
                    end else begin
                        phase_next = PH_MDATA;
                    end
                end
            end
            PH_MDATA: begin
                case (pcount_reg)
                    28'd0:   tshift_upd = tshift_reg | {b, 16'd0};
                    28'd1:   tshift_upd = tshift_reg | {8'd0, b, 8'd0};
                    28'd2:   tshift_upd = tshift_reg | {16'd0, b};
                    default: tshift_upd = tshift_reg;
                endcase
                tshift_next = tshift_upd;
                pcount_next = pcount_reg + 28'd1;
                r0_valid    = 1'b1;
                if (pcount_next == mlen_reg) begin
                    r0 = make_res(KIND_MBYTE, delta_reg, tick_reg, es_reg, 8'd0, 8'd0,
                                  mtype_reg, mlen_reg, b, tempo_reg, 1'b1);
                    if (mtype_reg == META_TEMPO) begin
                        tempo_next = tshift_upd;
                    end
                    r1_valid = 1'b1;
                    r1       = make_res(KIND_MDONE, delta_reg, tick_reg, es_reg, 8'd0, 8'd0,
                                        mtype_reg, mlen_reg, 8'd0,
                                        (mtype_reg == META_TEMPO) ? tshift_upd : tempo_reg,
                                        1'b0);
                    if (mtype_reg == META_END) begin
                        tick_next = 32'd0;
                    end
                    delta_next = 28'd0;
                    phase_next = PH_DELTA;
                end else begin
                    r0 = make_res(KIND_MBYTE, delta_reg, tick_reg, es_reg, 8'd0, 8'd0,
                                  mtype_reg, mlen_reg, b, tempo_reg, 1'b0);
                end
            end
            default: begin
                delta_next = 28'd0;
                phase_next = PH_DELTA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            delta_reg  <= 28'd0;
            tick_reg   <= 32'd0;
            rs_reg     <= 8'd0;
            es_reg     <= 8'd0;
            held_reg   <= 8'd0;
            mtype_reg  <= 8'd0;
            mlen_reg   <= 28'd0;
            pcount_reg <= 28'd0;
            tshift_reg <= 24'd0;
            tempo_reg  <= TEMPO_RESET;
        end else if (accept) begin
            phase_reg  <= phase_next;
            delta_reg  <= delta_next;
            tick_reg   <= tick_next;
            rs_reg     <= rs_next;
            es_reg     <= es_next;
            held_reg   <= held_next;
            mtype_reg  <= mtype_next;
            mlen_reg   <= mlen_next;
            pcount_reg <= pcount_next;
            tshift_reg <= tshift_next;
            tempo_reg  <= tempo_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (accept && r0_valid) begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (accept && r1_valid) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(accept && r0_valid) + PTR_W'(accept && r1_valid);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(accept && r0_valid)
                          + CNT_W'(accept && r1_valid) - CNT_W'(pop);
        end
    end

    assign s_ready        = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign m_valid        = count_reg != '0;
    assign m_kind         = fifo_reg[rd_ptr_reg].kind;
    assign m_delta_ticks  = fifo_reg[rd_ptr_reg].delta_ticks;
    assign m_abs_tick     = fifo_reg[rd_ptr_reg].abs_tick;
    assign m_status_byte  = fifo_reg[rd_ptr_reg].status_byte;
    assign m_first_data   = fifo_reg[rd_ptr_reg].first_data;
    assign m_second_data  = fifo_reg[rd_ptr_reg].second_data;
    assign m_meta_kind    = fifo_reg[rd_ptr_reg].meta_kind;
    assign m_meta_size    = fifo_reg[rd_ptr_reg].meta_size;
    assign m_payload_byte = fifo_reg[rd_ptr_reg].payload_byte;
    assign m_tempo_us     = fifo_reg[rd_ptr_reg].tempo_us;
    assign m_last         = fifo_reg[rd_ptr_reg].last;

    `MTEP_ASSERT(a_count_bound, count_reg <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `MTEP_ASSERT(a_second_needs_first, !r1_valid || r0_valid, "second result without first")
    `MTEP_ASSERT(a_pair_shape, !r1_valid || (r0.kind == KIND_MBYTE && r0.last && r1.kind == KIND_MDONE), "bad result pair")
    `MTEP_ASSERT_NEXT(a_pop_only, pop && !accept, count_reg == $past(count_reg) - CNT_W'(1), "queue count not decremented")
    `MTEP_ASSERT_NEXT(a_end_clears_tick, accept && ((r0_valid && r0.kind == KIND_MDONE) || r1_valid) && mtype_reg == META_END, tick_reg == 32'd0, "end of track did not clear tick count")

endmodule

// ----- dv/midi_track_event_parser_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for midi_track_event_parser: directed and random byte streams,
// a bit-exact event decoder in a scoreboard class, random stalls on both channels
// depends on mtep_pkg and the midi_track_event_parser rtl
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 600;
    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] NOTE_ON    = 8'h90;
    localparam logic [7:0] SYS_COMMON = 8'hF5;

    class midi_event_scoreboard;
        phase_t      ph;
        logic [27:0] delta_acc;
        logic [31:0] ticks;
        logic [7:0]  run_status;
        logic [7:0]  evt_status;
        logic [7:0]  held;
        logic [7:0]  meta_type;
        logic [27:0] meta_len;
        logic [27:0] pay_cnt;
        logic [23:0] tempo_build;
        logic [23:0] tempo;
        res_t        pending_results[$];
        int          failures;
        int          checked;

        function new();
            ph = PH_DELTA;
            delta_acc = '0;
            ticks = '0;
            run_status = '0;
            evt_status = '0;
            held = '0;
            meta_type = '0;
            meta_len = '0;
            pay_cnt = '0;
            tempo_build = '0;
            tempo = TEMPO_RESET;
            failures = 0;
            checked = 0;
        endfunction

        function void add_result(logic [2:0] kind, logic [7:0] d1, logic [7:0] d2,
                                 logic [7:0] pay, logic fin);
            res_t r;
            logic is_meta;
            is_meta = (kind == KIND_MDONE) || (kind == KIND_MBYTE);
            r.kind         = kind;
            r.delta_ticks  = delta_acc;
            r.abs_tick     = ticks;
            r.status_byte  = evt_status;
            r.first_data   = d1;
            r.second_data  = d2;
            r.meta_kind    = is_meta ? meta_type : 8'd0;
            r.meta_size    = is_meta ? meta_len : 28'd0;
            r.payload_byte = pay;
            r.tempo_us     = tempo;
            r.last         = fin;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void start_delta();
            ph = PH_DELTA;
            delta_acc = '0;
        endfunction

        function void close_meta();
            if (meta_type == META_TEMPO) tempo = tempo_build;
            add_result(KIND_MDONE, 8'd0, 8'd0, 8'd0, 1'b0);
            if (meta_type == META_END) ticks = '0;
            start_delta();
        endfunction

        // returns 0 when the byte has to be decoded again in the new phase
        function bit take_byte(logic [7:0] b);
            logic [7:0] s;
            logic [3:0] hi;
            case (ph)
                PH_DELTA: begin
                    delta_acc = {delta_acc[20:0], b[6:0]};
                    if (!b[7]) begin
                        ticks += {4'd0, delta_acc};
                        ph = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b[7]) run_status = b;
                    s = b[7] ? b : run_status;
                    evt_status = s;
                    hi = s[7:4];
                    if (hi >= 4'h8 && hi <= 4'hE) begin
                        held = '0;
                        ph = PH_DATA1;
                    end else if (s == STATUS_SYSEX) begin
                        ph = PH_SYSEX;
                    end else if (s == STATUS_META) begin
                        ph = PH_MTYPE;
                    end else if (!s[7]) begin
                        add_result(KIND_ERR, 8'd0, 8'd0, 8'd0, 1'b0);
                        start_delta();
                    end else begin
                        start_delta();
                    end
                    return b[7];
                end
                PH_DATA1: begin
                    held = b;
                    if (evt_status[7:4] == HI_PROG || evt_status[7:4] == HI_PRESSURE) begin
                        add_result(KIND_CHAN, b, 8'd0, 8'd0, 1'b0);
                        start_delta();
                    end else begin
                        ph = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    add_result(KIND_CHAN, held, b, 8'd0, 1'b0);
                    start_delta();
                end
                PH_SYSEX: begin
                    add_result(KIND_SYSEX, 8'd0, 8'd0, b, b == SYSEX_END);
                    if (b == SYSEX_END) start_delta();
                end
                PH_MTYPE: begin
                    meta_type = b;
                    meta_len = '0;
                    pay_cnt = '0;
                    tempo_build = '0;
                    ph = PH_MLEN;
                end
                PH_MLEN: begin
                    meta_len = {meta_len[20:0], b[6:0]};
                    if (!b[7]) begin
                        if (meta_len == 28'd0) close_meta();
                        else ph = PH_MDATA;
                    end
                end
                PH_MDATA: begin
                    case (pay_cnt)
                        28'd0: tempo_build[23:16] = b;
                        28'd1: tempo_build[15:8] = b;
                        28'd2: tempo_build[7:0] = b;
                        default: ;
                    endcase
                    pay_cnt = pay_cnt + 28'd1;
                    if (pay_cnt == meta_len) begin
                        add_result(KIND_MBYTE, 8'd0, 8'd0, b, 1'b1);
                        close_meta();
                    end else begin
                        add_result(KIND_MBYTE, 8'd0, 8'd0, b, 1'b0);
                    end
                end
                default: begin
                    start_delta();
                    return 1'b0;
                end
            endcase
            return 1'b1;
        endfunction

        function void decode_byte(logic [7:0] b);
            bit done;
            int pass;
            done = 1'b0;
            for (pass = 0; pass < 3; pass++) begin
                if (!done) done = take_byte(b);
            end
        endfunction

        function string field_diff(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) return $sformatf(" %s exp %0h got %0h", name, want, got);
            return "";
        endfunction

        function void check_result(res_t got);
            res_t  want;
            string diff;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: kind %0d status %0h payload %0h",
                             got.kind, got.status_byte, got.payload_byte);
                return;
            end
            want = pending_results.pop_front();
            diff = {field_diff("kind", want.kind, got.kind),
                    field_diff("delta_ticks", want.delta_ticks, got.delta_ticks),
                    field_diff("abs_tick", want.abs_tick, got.abs_tick),
                    field_diff("status_byte", want.status_byte, got.status_byte),
                    field_diff("first_data", want.first_data, got.first_data),
                    field_diff("second_data", want.second_data, got.second_data),
                    field_diff("meta_kind", want.meta_kind, got.meta_kind),
                    field_diff("meta_size", want.meta_size, got.meta_size),
                    field_diff("payload_byte", want.payload_byte, got.payload_byte),
                    field_diff("tempo_us", want.tempo_us, got.tempo_us),
                    field_diff("last", want.last, got.last)};
            if (diff != "") begin
                failures++;
                if (failures <= MAX_REPORTS) $display("result %0d mismatch:%s", checked, diff);
            end
            checked++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [27:0] m_delta_ticks;
    logic [31:0] m_abs_tick;
    logic [7:0]  m_status_byte;
    logic [7:0]  m_first_data;
    logic [7:0]  m_second_data;
    logic [7:0]  m_meta_kind;
    logic [27:0] m_meta_size;
    logic [7:0]  m_payload_byte;
    logic [23:0] m_tempo_us;
    logic        m_last;

    midi_event_scoreboard sb;
    bit          tx_gaps;
    bit          rx_gaps;
    int          items_sent;
    int unsigned cycle_count;
    logic [7:0]  last_status;

    midi_track_event_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_delta_ticks  (m_delta_ticks),
        .m_abs_tick     (m_abs_tick),
        .m_status_byte  (m_status_byte),
        .m_first_data   (m_first_data),
        .m_second_data  (m_second_data),
        .m_meta_kind    (m_meta_kind),
        .m_meta_size    (m_meta_size),
        .m_payload_byte (m_payload_byte),
        .m_tempo_us     (m_tempo_us),
        .m_last         (m_last)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{kind: m_kind, delta_ticks: m_delta_ticks, abs_tick: m_abs_tick,
                              status_byte: m_status_byte, first_data: m_first_data,
                              second_data: m_second_data, meta_kind: m_meta_kind,
                              meta_size: m_meta_size, payload_byte: m_payload_byte,
                              tempo_us: m_tempo_us, last: m_last});
    end

    // result side stalls in bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_gaps && $urandom_range(0, 3) == 0) m_ready <= 1'b0;
            else m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.decode_byte(b);
        items_sent++;
    endtask

    // variable-length quantity, optionally padded past four bytes
    task automatic send_quantity(input logic [27:0] v, input bit stretched);
        int groups;
        int i;
        groups = 1;
        while (groups < 4 && (v >> (7 * groups)) != 0) groups++;
        if (stretched) begin
            repeat ($urandom_range(1, 2)) send_byte(8'h80 | 8'($urandom_range(0, 127)));
            groups = 4;
        end
        for (i = groups - 1; i >= 0; i--) send_byte({i != 0, v[7 * i +: 7]});
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_event();
        int          pick;
        int          d;
        int          count;
        bit          chan_running;
        logic [7:0]  st;
        logic [7:0]  b;
        logic [27:0] mlen;
        d = $urandom_range(0, 99);
        if (d < 50) send_quantity(28'd0, 1'b0);
        else if (d < 80) send_quantity(28'($urandom_range(1, 127)), 1'b0);
        else if (d < 92) send_quantity(28'($urandom_range(128, 28'h1FFFFF)), 1'b0);
        else send_quantity(28'($urandom), d >= 97);
        chan_running = last_status[7:4] >= 4'h8 && last_status[7:4] <= 4'hE;
        pick = $urandom_range(0, 99);
        if (pick < 35 || (pick < 50 && !chan_running)) begin
            st = {4'($urandom_range(8, 14)), 4'($urandom)};
            send_byte(st);
            last_status = st;
            send_byte(data_byte());
            if (st[7:4] != HI_PROG && st[7:4] != HI_PRESSURE) send_byte(data_byte());
        end else if (pick < 50) begin
            send_byte(data_byte());
            if (last_status[7:4] != HI_PROG && last_status[7:4] != HI_PRESSURE)
                send_byte(data_byte());
        end else if (pick < 60) begin
            send_byte(STATUS_SYSEX);
            last_status = STATUS_SYSEX;
            count = $urandom_range(0, 6);
            repeat (count) begin
                do b = 8'($urandom); while (b == SYSEX_END);
                send_byte(b);
            end
            send_byte(SYSEX_END);
        end else if (pick < 85) begin
            send_byte(STATUS_META);
            last_status = STATUS_META;
            d = $urandom_range(0, 9);
            st = (d < 4) ? META_TEMPO : (d == 4) ? META_END : 8'($urandom);
            send_byte(st);
            mlen = 28'($urandom_range(0, (st == META_TEMPO) ? 5 : 6));
            send_quantity(mlen, $urandom_range(0, 9) == 0);
            repeat (int'(mlen)) send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
        end else if (pick < 92) begin
            st = 8'($urandom_range(8'hF1, 8'hFE));
            send_byte(st);
            last_status = st;
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        int k;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_byte_in = 8'd0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        items_sent = 0;
        last_status = STATUS_META;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // data byte with no status, then a note on
        send_byte(8'h00); send_byte(8'h45);
        send_byte(NOTE_ON); send_byte(8'h3C); send_byte(8'h7F);
        // five-byte delta, running status
        repeat (4) send_byte(8'hFF);
        send_byte(8'h7F); send_byte(8'h3C); send_byte(8'h40);
        // one-byte set tempo
        send_byte(8'h00); send_byte(STATUS_META); send_byte(META_TEMPO);
        send_byte(8'h01); send_byte(8'hFF);
        send_byte(8'h00); send_byte(STATUS_SYSEX); send_byte(8'h80); send_byte(SYSEX_END);
        // system common status explicit and running
        send_byte(8'h00); send_byte(SYS_COMMON); send_byte(8'h00); send_byte(8'h12);
        send_byte(STATUS_META); send_byte(META_END); send_byte(8'h00);
        drain();

        // maximal deltas until the tick count wraps
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        for (k = 0; k < 18; k++) begin
            send_quantity(28'h0FFFFFFF, 1'b0);
            if (k == 0 || $urandom_range(0, 1) == 0) send_byte(NOTE_ON | 8'($urandom_range(0, 15)));
            send_byte(data_byte());
            send_byte(data_byte());
        end
        last_status = NOTE_ON;
        drain();

        while (items_sent < ITEM_TARGET - 80) begin
            tx_gaps = $urandom_range(0, 1);
            rx_gaps = $urandom_range(0, 1);
            repeat (12) send_event();
        end

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (items_sent < ITEM_TARGET) send_event();
        // meta with the widest size, left open
        send_byte(8'h00);
        send_byte(STATUS_META);
        send_byte(8'($urandom));
        send_quantity(28'h0FFFFFFF, 1'b0);
        repeat (4) send_byte(8'($urandom));

        drain();
        repeat (32) @(posedge aclk);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
